[rtl/core/tcm_pkg.sv]
// Shared types, codes and helpers for the tensor contraction block.
// No dependencies; every other file refers to it by scoped names.
package tcm_pkg;

   localparam int DATA_W    = 32;
   localparam int ACC_W     = 48;
   localparam int PROD_W    = 64;
   localparam int IDX_W     = 12;
   localparam int RIDX_W    = 9;
   localparam int CNT_W     = 4;
   localparam int ACT_W     = 3;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;

   localparam logic [ACT_W-1:0] ACT_LOAD_A  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LOAD_U  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_LOAD_B  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_COMPUTE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_X_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_W_COUNT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_U_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_A_COUNT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_REP_COUNT = 3'd4;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic [ACC_W-1:0]  ACC_MAX   = 48'h7FFF_FFFF_FFFF;
   localparam logic [ACC_W-1:0]  ACC_MIN   = 48'h8000_0000_0000;
   localparam logic [PROD_W-1:0] TERM_POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [PROD_W-1:0] TERM_NEG_LIM = 64'h0000_8000_0000_0000;
   localparam logic [DATA_W-1:0] OUT_MAX   = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] OUT_MIN   = 32'h8000_0000;

   typedef struct packed {
      logic [CNT_W-1:0] x;
      logic [CNT_W-1:0] w;
      logic [CNT_W-1:0] u;
      logic [CNT_W-1:0] a;
      logic [CNT_W-1:0] r;
   } dims_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_READ,
      TOP_COMP
   } top_state_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_FETCH,
      SQ_MAU,
      SQ_MLO,
      SQ_MHI,
      SQ_TERM,
      SQ_ACC,
      SQ_WRITE
   } seq_state_type;

   typedef enum logic [2:0] {
      MAC_HOLD,
      MAC_CLEAR,
      MAC_AU,
      MAC_LO,
      MAC_HI,
      MAC_TERM,
      MAC_ACC
   } mac_op_type;

   function automatic int addr_width(int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] value, int maxv);
      if (value == '0) begin
         return CNT_W'(1);
      end else if (int'(value) > maxv) begin
         return CNT_W'(maxv);
      end else begin
         return value;
      end
   endfunction

endpackage

[rtl/core/tcm_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Uses tcm_pkg for the address width helper.
module tcm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [tcm_pkg::addr_width(DEPTH)-1:0]     wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [tcm_pkg::addr_width(DEPTH)-1:0]     rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/tcm_mac.sv]
// Shared multiply-accumulate unit: one 32x32 unsigned multiplier used three
// times per term, term truncation/saturation and 48-bit saturating accumulator.
// Depends on tcm_pkg.
module tcm_mac (
   input  logic                         clock,
   input  tcm_pkg::mac_op_type          op,
   input  logic [tcm_pkg::DATA_W-1:0]   a_data,
   input  logic [tcm_pkg::DATA_W-1:0]   u_data,
   input  logic [tcm_pkg::DATA_W-1:0]   b_data,
   output logic [tcm_pkg::DATA_W-1:0]   sum
);

   function automatic logic [tcm_pkg::DATA_W-1:0] mag(logic [tcm_pkg::DATA_W-1:0] v);
      return v[tcm_pkg::DATA_W-1] ? (tcm_pkg::DATA_W'(0) - v) : v;
   endfunction

   logic [tcm_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [tcm_pkg::DATA_W-1:0] lo_ff, lo_in;
   logic [tcm_pkg::DATA_W-1:0] mb_ff, mb_in;
   logic                       neg_ff, neg_in;
   logic [tcm_pkg::ACC_W-1:0]  term_ff, term_in;
   logic [tcm_pkg::ACC_W-1:0]  acc_ff, acc_in;

   logic [tcm_pkg::DATA_W-1:0] mul_x, mul_y;
   logic [tcm_pkg::PROD_W-1:0] mul_p;
   logic [tcm_pkg::PROD_W-1:0] q;
   logic [tcm_pkg::ACC_W:0]    acc_sum;

   always_comb begin
      case (op)
         tcm_pkg::MAC_AU: begin
            mul_x = mag(a_data);
            mul_y = mag(u_data);
         end
         tcm_pkg::MAC_LO: begin
            mul_x = prod_ff[tcm_pkg::DATA_W-1:0];
            mul_y = mb_ff;
         end
         tcm_pkg::MAC_HI: begin
            mul_x = prod_ff[tcm_pkg::PROD_W-1:tcm_pkg::DATA_W];
            mul_y = mb_ff;
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign mul_p   = tcm_pkg::PROD_W'(mul_x) * tcm_pkg::PROD_W'(mul_y);
   assign q       = prod_ff + tcm_pkg::PROD_W'(lo_ff);
   assign acc_sum = {acc_ff[tcm_pkg::ACC_W-1], acc_ff} + {term_ff[tcm_pkg::ACC_W-1], term_ff};

   always_comb begin
      prod_in = prod_ff;
      lo_in   = lo_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      term_in = term_ff;
      acc_in  = acc_ff;
      case (op)
         tcm_pkg::MAC_CLEAR: begin
            acc_in = '0;
         end
         tcm_pkg::MAC_AU: begin
            prod_in = mul_p;
            mb_in   = mag(b_data);
            neg_in  = a_data[tcm_pkg::DATA_W-1] ^ u_data[tcm_pkg::DATA_W-1]
                      ^ b_data[tcm_pkg::DATA_W-1];
         end
         tcm_pkg::MAC_LO: begin
            lo_in = mul_p[tcm_pkg::PROD_W-1:tcm_pkg::DATA_W];
         end
         tcm_pkg::MAC_HI: begin
            prod_in = mul_p;
         end
         tcm_pkg::MAC_TERM: begin
            if (neg_ff) begin
               term_in = (q > tcm_pkg::TERM_NEG_LIM) ? tcm_pkg::ACC_MIN
                         : tcm_pkg::ACC_W'(tcm_pkg::PROD_W'(0) - q);
            end else begin
               term_in = (q > tcm_pkg::TERM_POS_LIM) ? tcm_pkg::ACC_MAX
                         : q[tcm_pkg::ACC_W-1:0];
            end
         end
         tcm_pkg::MAC_ACC: begin
            if (acc_sum[tcm_pkg::ACC_W] != acc_sum[tcm_pkg::ACC_W-1]) begin
               acc_in = acc_sum[tcm_pkg::ACC_W] ? tcm_pkg::ACC_MIN : tcm_pkg::ACC_MAX;
            end else begin
               acc_in = acc_sum[tcm_pkg::ACC_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      lo_ff   <= lo_in;
      mb_ff   <= mb_in;
      neg_ff  <= neg_in;
      term_ff <= term_in;
      acc_ff  <= acc_in;
   end

   // saturate to 32 bits
   always_comb begin
      if ((&acc_ff[tcm_pkg::ACC_W-1:tcm_pkg::DATA_W-1])
          || (~|acc_ff[tcm_pkg::ACC_W-1:tcm_pkg::DATA_W-1])) begin
         sum = acc_ff[tcm_pkg::DATA_W-1:0];
      end else begin
         sum = acc_ff[tcm_pkg::ACC_W-1] ? tcm_pkg::OUT_MIN : tcm_pkg::OUT_MAX;
      end
   end

endmodule

[rtl/core/tcm_seq.sv]
// Compute sequencer: walks r, i, j, k, l, drives store read addresses, steps
// the shared MAC through its phases and writes each finished output element.
// Depends on tcm_pkg.
module tcm_seq #(
   parameter int VEC_DEPTH = 8,
   parameter int MAT_DEPTH = 64,
   parameter int TEN_DEPTH = 4096,
   parameter int OUT_DEPTH = 512
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  tcm_pkg::dims_type                         dims,
   output logic [tcm_pkg::addr_width(VEC_DEPTH)-1:0] vec_addr,
   output logic [tcm_pkg::addr_width(MAT_DEPTH)-1:0] mat_addr,
   output logic [tcm_pkg::addr_width(TEN_DEPTH)-1:0] ten_addr,
   output logic                                      out_we,
   output logic [tcm_pkg::addr_width(OUT_DEPTH)-1:0] out_addr,
   output tcm_pkg::mac_op_type                       mac_op,
   output logic                                      done
);

   localparam int VEC_AW = tcm_pkg::addr_width(VEC_DEPTH);
   localparam int MAT_AW = tcm_pkg::addr_width(MAT_DEPTH);
   localparam int TEN_AW = tcm_pkg::addr_width(TEN_DEPTH);
   localparam int OUT_AW = tcm_pkg::addr_width(OUT_DEPTH);

   tcm_pkg::seq_state_type state_ff, state_in;

   logic [tcm_pkg::CNT_W-1:0] l_ff, l_in, k_ff, k_in, j_ff, j_in;
   logic [tcm_pkg::CNT_W-1:0] i_ff, i_in, r_ff, r_in;
   logic [TEN_AW-1:0]         ten_ptr_ff, ten_ptr_in;
   logic [MAT_AW-1:0]         mat_base_ff, mat_base_in;
   logic [OUT_AW-1:0]         ir_ff, ir_in;
   logic [OUT_AW-1:0]         joff_ff, joff_in;

   logic [2*tcm_pkg::CNT_W-1:0] rx;
   logic last_l, last_k, last_j, last_i, last_r;

   assign rx     = (2*tcm_pkg::CNT_W)'(dims.r) * (2*tcm_pkg::CNT_W)'(dims.x);
   assign last_l = (l_ff == dims.a - tcm_pkg::CNT_W'(1));
   assign last_k = (k_ff == dims.u - tcm_pkg::CNT_W'(1));
   assign last_j = (j_ff == dims.w - tcm_pkg::CNT_W'(1));
   assign last_i = (i_ff == dims.x - tcm_pkg::CNT_W'(1));
   assign last_r = (r_ff == dims.r - tcm_pkg::CNT_W'(1));

   assign vec_addr = VEC_AW'(l_ff);
   assign mat_addr = mat_base_ff + MAT_AW'(k_ff);
   assign ten_addr = ten_ptr_ff;
   assign out_addr = ir_ff + joff_ff;

   always_comb begin
      state_in    = state_ff;
      l_in        = l_ff;
      k_in        = k_ff;
      j_in        = j_ff;
      i_in        = i_ff;
      r_in        = r_ff;
      ten_ptr_in  = ten_ptr_ff;
      mat_base_in = mat_base_ff;
      ir_in       = ir_ff;
      joff_in     = joff_ff;
      out_we      = 1'b0;
      done        = 1'b0;
      mac_op      = tcm_pkg::MAC_HOLD;
      case (state_ff)
         tcm_pkg::SQ_IDLE: begin
            mac_op = tcm_pkg::MAC_CLEAR;
            if (start) begin
               l_in        = '0;
               k_in        = '0;
               j_in        = '0;
               i_in        = '0;
               r_in        = '0;
               ten_ptr_in  = '0;
               mat_base_in = '0;
               ir_in       = '0;
               joff_in     = '0;
               state_in    = tcm_pkg::SQ_FETCH;
            end
         end
         tcm_pkg::SQ_FETCH: begin
            state_in = tcm_pkg::SQ_MAU;
         end
         tcm_pkg::SQ_MAU: begin
            mac_op   = tcm_pkg::MAC_AU;
            state_in = tcm_pkg::SQ_MLO;
         end
         tcm_pkg::SQ_MLO: begin
            mac_op   = tcm_pkg::MAC_LO;
            state_in = tcm_pkg::SQ_MHI;
         end
         tcm_pkg::SQ_MHI: begin
            mac_op   = tcm_pkg::MAC_HI;
            state_in = tcm_pkg::SQ_TERM;
         end
         tcm_pkg::SQ_TERM: begin
            mac_op   = tcm_pkg::MAC_TERM;
            state_in = tcm_pkg::SQ_ACC;
         end
         tcm_pkg::SQ_ACC: begin
            mac_op     = tcm_pkg::MAC_ACC;
            ten_ptr_in = ten_ptr_ff + TEN_AW'(1);
            state_in   = tcm_pkg::SQ_FETCH;
            if (!last_l) begin
               l_in = l_ff + tcm_pkg::CNT_W'(1);
            end else begin
               l_in = '0;
               if (!last_k) begin
                  k_in = k_ff + tcm_pkg::CNT_W'(1);
               end else begin
                  k_in     = '0;
                  state_in = tcm_pkg::SQ_WRITE;
               end
            end
         end
         tcm_pkg::SQ_WRITE: begin
            mac_op   = tcm_pkg::MAC_CLEAR;
            out_we   = 1'b1;
            state_in = tcm_pkg::SQ_FETCH;
            if (!last_j) begin
               j_in    = j_ff + tcm_pkg::CNT_W'(1);
               joff_in = joff_ff + OUT_AW'(rx);
            end else begin
               j_in    = '0;
               joff_in = '0;
               ir_in   = ir_ff + OUT_AW'(1);
               if (!last_i) begin
                  i_in = i_ff + tcm_pkg::CNT_W'(1);
               end else begin
                  i_in = '0;
                  if (!last_r) begin
                     r_in        = r_ff + tcm_pkg::CNT_W'(1);
                     mat_base_in = mat_base_ff + MAT_AW'(dims.u);
                     ten_ptr_in  = '0;
                  end else begin
                     done     = 1'b1;
                     state_in = tcm_pkg::SQ_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = tcm_pkg::SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tcm_pkg::SQ_IDLE;
         l_ff        <= '0;
         k_ff        <= '0;
         j_ff        <= '0;
         i_ff        <= '0;
         r_ff        <= '0;
         ten_ptr_ff  <= '0;
         mat_base_ff <= '0;
         ir_ff       <= '0;
         joff_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         l_ff        <= l_in;
         k_ff        <= k_in;
         j_ff        <= j_in;
         i_ff        <= i_in;
         r_ff        <= r_in;
         ten_ptr_ff  <= ten_ptr_in;
         mat_base_ff <= mat_base_in;
         ir_ff       <= ir_in;
         joff_ff     <= joff_in;
      end
   end

   a_acc_after_term: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcm_pkg::SQ_ACC) |-> ($past(state_ff) == tcm_pkg::SQ_TERM))
      else $error("accumulate step without a preceding term step");

   a_ten_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tcm_pkg::SQ_IDLE) |-> (int'(ten_addr) < TEN_DEPTH))
      else $error("tensor address beyond store depth");

   a_out_in_range: assert property (@(posedge clock) disable iff (reset)
      out_we |-> (int'(out_addr) < OUT_DEPTH))
      else $error("output write beyond store depth");

endmodule

[rtl/core/tensor_contraction_mac.sv]
// Four-way tensor contraction with one shared multiply-accumulate. Load items
// (vector a, matrix u, tensor b) and unused action codes are done when taken; a
// read of the output store waits on the registered RAM read. A compute item
// holds the input off until it is done: each term steps through a fetch, the
// single 32x32 multiplier (a*u, then the low and high halves of that product
// times b), term saturation and the 48-bit accumulate, and each output element
// takes one more step to write it.
// While a result beat waits on rsp_tready no new beat is taken. The output
// store needs no clearing pass: reads beyond the extent of the last compute
// return zero.
// Depends on tcm_pkg, tcm_ram, tcm_mac and tcm_seq.
module tensor_contraction_mac #(
   parameter int MAX_X = 8,
   parameter int MAX_W = 8,
   parameter int MAX_U = 8,
   parameter int MAX_A = 8,
   parameter int MAX_R = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [tcm_pkg::REQ_DATA_W-1:0]         req_tdata,  // elem_index, load_value, zero pad
   input  logic [tcm_pkg::ACT_W-1:0]              req_tuser,  // action
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [tcm_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // result_index, result_value, zero pad
   output logic                                   rsp_tuser,  // status
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tcm_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [tcm_pkg::CNT_W-1:0]              csr_data
);

   localparam int VEC_DEPTH = MAX_A;
   localparam int MAT_DEPTH = MAX_U * MAX_R;
   localparam int TEN_DEPTH = MAX_X * MAX_W * MAX_U * MAX_A;
   localparam int OUT_DEPTH = MAX_X * MAX_R * MAX_W;
   localparam int VEC_AW = tcm_pkg::addr_width(VEC_DEPTH);
   localparam int MAT_AW = tcm_pkg::addr_width(MAT_DEPTH);
   localparam int TEN_AW = tcm_pkg::addr_width(TEN_DEPTH);
   localparam int OUT_AW = tcm_pkg::addr_width(OUT_DEPTH);
   localparam int DW = tcm_pkg::DATA_W;
   localparam int IW = tcm_pkg::IDX_W;
   localparam int CW = tcm_pkg::CNT_W;

   // configuration
   logic [CW-1:0] x_count_ff, x_count_in, w_count_ff, w_count_in, u_count_ff, u_count_in;
   logic [CW-1:0] a_count_ff, a_count_in, rep_count_ff, rep_count_in;
   tcm_pkg::dims_type dims;

   // request fields
   logic [tcm_pkg::ACT_W-1:0] req_action;
   logic [IW-1:0]             req_index;
   logic [DW-1:0]             req_value;
   logic                      req_accept;

   logic [2*CW-1:0] mat_lim;
   logic [4*CW-1:0] ten_lim;
   logic [IW-1:0]   out_lim;
   logic vec_ok, mat_ok, ten_ok, out_ok;

   tcm_pkg::top_state_type state_ff, state_in;
   logic [IW-1:0]               fill_ff, fill_in;
   logic [tcm_pkg::RIDX_W-1:0]  rd_index_ff, rd_index_in;
   logic                        rd_ok_ff, rd_ok_in, rd_hit_ff, rd_hit_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_load;
   logic [tcm_pkg::RIDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [DW-1:0]               rsp_value_ff, rsp_value_in;
   logic                        rsp_status_ff, rsp_status_in;

   logic vec_we, mat_we, ten_we, seq_start, seq_done, seq_out_we;
   logic [VEC_AW-1:0] seq_vec_addr;
   logic [MAT_AW-1:0] seq_mat_addr;
   logic [TEN_AW-1:0] seq_ten_addr;
   logic [OUT_AW-1:0] seq_out_addr;
   logic [DW-1:0]     vec_rdata, mat_rdata, ten_rdata, out_rdata, mac_sum;
   tcm_pkg::mac_op_type mac_op;

   assign req_action = req_tuser;
   assign req_index  = req_tdata[IW-1:0];
   assign req_value  = req_tdata[IW+DW-1:IW];
   assign req_tready = (state_ff == tcm_pkg::TOP_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_comb begin
      x_count_in   = x_count_ff;
      w_count_in   = w_count_ff;
      u_count_in   = u_count_ff;
      a_count_in   = a_count_ff;
      rep_count_in = rep_count_ff;
      if (csr_valid) begin
         case (csr_index)
            tcm_pkg::REG_X_COUNT:   x_count_in   = csr_data;
            tcm_pkg::REG_W_COUNT:   w_count_in   = csr_data;
            tcm_pkg::REG_U_COUNT:   u_count_in   = csr_data;
            tcm_pkg::REG_A_COUNT:   a_count_in   = csr_data;
            tcm_pkg::REG_REP_COUNT: rep_count_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_count_ff   <= CW'(1);
         w_count_ff   <= CW'(1);
         u_count_ff   <= CW'(1);
         a_count_ff   <= CW'(1);
         rep_count_ff <= CW'(1);
      end else begin
         x_count_ff   <= x_count_in;
         w_count_ff   <= w_count_in;
         u_count_ff   <= u_count_in;
         a_count_ff   <= a_count_in;
         rep_count_ff <= rep_count_in;
      end
   end

   assign dims.x = tcm_pkg::eff_count(x_count_ff, MAX_X);
   assign dims.w = tcm_pkg::eff_count(w_count_ff, MAX_W);
   assign dims.u = tcm_pkg::eff_count(u_count_ff, MAX_U);
   assign dims.a = tcm_pkg::eff_count(a_count_ff, MAX_A);
   assign dims.r = tcm_pkg::eff_count(rep_count_ff, MAX_R);

   assign mat_lim = (2*CW)'(dims.u) * (2*CW)'(dims.r);
   assign ten_lim = (4*CW)'(dims.x) * (4*CW)'(dims.w) * (4*CW)'(dims.u) * (4*CW)'(dims.a);
   assign out_lim = IW'(dims.x) * IW'(dims.r) * IW'(dims.w);

   assign vec_ok = req_index < IW'(dims.a);
   assign mat_ok = req_index < IW'(mat_lim);
   assign ten_ok = (4*CW)'(req_index) < ten_lim;
   assign out_ok = req_index < out_lim;

   assign vec_we = req_accept && (req_action == tcm_pkg::ACT_LOAD_A) && vec_ok;
   assign mat_we = req_accept && (req_action == tcm_pkg::ACT_LOAD_U) && mat_ok;
   assign ten_we = req_accept && (req_action == tcm_pkg::ACT_LOAD_B) && ten_ok;

   // item control
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rd_index_in   = rd_index_ff;
      rd_ok_in      = rd_ok_ff;
      rd_hit_in     = rd_hit_ff;
      seq_start     = 1'b0;
      rsp_load      = 1'b0;
      rsp_index_in  = '0;
      rsp_value_in  = '0;
      rsp_status_in = tcm_pkg::STATUS_OK;
      case (state_ff)
         tcm_pkg::TOP_IDLE: begin
            if (req_accept) begin
               case (req_action)
                  tcm_pkg::ACT_LOAD_A: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = vec_ok ? tcm_pkg::STATUS_OK : tcm_pkg::STATUS_RANGE;
                  end
                  tcm_pkg::ACT_LOAD_U: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = mat_ok ? tcm_pkg::STATUS_OK : tcm_pkg::STATUS_RANGE;
                  end
                  tcm_pkg::ACT_LOAD_B: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = ten_ok ? tcm_pkg::STATUS_OK : tcm_pkg::STATUS_RANGE;
                  end
                  tcm_pkg::ACT_COMPUTE: begin
                     seq_start = 1'b1;
                     fill_in   = out_lim;
                     state_in  = tcm_pkg::TOP_COMP;
                  end
                  tcm_pkg::ACT_READ: begin
                     rd_index_in = req_index[tcm_pkg::RIDX_W-1:0];
                     rd_ok_in    = out_ok;
                     rd_hit_in   = req_index < fill_ff;
                     state_in    = tcm_pkg::TOP_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         tcm_pkg::TOP_READ: begin
            rsp_load      = 1'b1;
            rsp_index_in  = rd_index_ff;
            rsp_value_in  = (rd_ok_ff && rd_hit_ff) ? out_rdata : '0;
            rsp_status_in = rd_ok_ff ? tcm_pkg::STATUS_OK : tcm_pkg::STATUS_RANGE;
            state_in      = tcm_pkg::TOP_IDLE;
         end
         tcm_pkg::TOP_COMP: begin
            if (seq_done) begin
               rsp_load = 1'b1;
               state_in = tcm_pkg::TOP_IDLE;
            end
         end
         default: begin
            state_in = tcm_pkg::TOP_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcm_pkg::TOP_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_index_ff <= rd_index_in;
      rd_ok_ff    <= rd_ok_in;
      rd_hit_ff   <= rd_hit_in;
      if (rsp_load) begin
         rsp_index_ff  <= rsp_index_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = tcm_pkg::RSP_DATA_W'({rsp_value_ff, rsp_index_ff});
   assign rsp_tuser  = rsp_status_ff;

   tcm_ram #(.WIDTH(DW), .DEPTH(VEC_DEPTH)) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (VEC_AW'(req_index)),
      .wr_data (req_value),
      .rd_addr (seq_vec_addr),
      .rd_data (vec_rdata)
   );

   tcm_ram #(.WIDTH(DW), .DEPTH(MAT_DEPTH)) u_mat_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (MAT_AW'(req_index)),
      .wr_data (req_value),
      .rd_addr (seq_mat_addr),
      .rd_data (mat_rdata)
   );

   tcm_ram #(.WIDTH(DW), .DEPTH(TEN_DEPTH)) u_ten_ram (
      .clock   (clock),
      .wr_en   (ten_we),
      .wr_addr (TEN_AW'(req_index)),
      .wr_data (req_value),
      .rd_addr (seq_ten_addr),
      .rd_data (ten_rdata)
   );

   tcm_ram #(.WIDTH(DW), .DEPTH(OUT_DEPTH)) u_out_ram (
      .clock   (clock),
      .wr_en   (seq_out_we),
      .wr_addr (seq_out_addr),
      .wr_data (mac_sum),
      .rd_addr (OUT_AW'(req_index)),
      .rd_data (out_rdata)
   );

   tcm_seq #(
      .VEC_DEPTH (VEC_DEPTH),
      .MAT_DEPTH (MAT_DEPTH),
      .TEN_DEPTH (TEN_DEPTH),
      .OUT_DEPTH (OUT_DEPTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (seq_start),
      .dims     (dims),
      .vec_addr (seq_vec_addr),
      .mat_addr (seq_mat_addr),
      .ten_addr (seq_ten_addr),
      .out_we   (seq_out_we),
      .out_addr (seq_out_addr),
      .mac_op   (mac_op),
      .done     (seq_done)
   );

   tcm_mac u_mac (
      .clock  (clock),
      .op     (mac_op),
      .a_data (vec_rdata),
      .u_data (mat_rdata),
      .b_data (ten_rdata),
      .sum    (mac_sum)
   );

   a_out_write_in_compute: assert property (@(posedge clock) disable iff (reset)
      seq_out_we |-> (state_ff == tcm_pkg::TOP_COMP))
      else $error("output store written outside a compute");

   a_read_beat: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_action == tcm_pkg::ACT_READ)) |-> ##2 rsp_tvalid)
      else $error("read beat did not produce a result");

   a_compute_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_action == tcm_pkg::ACT_COMPUTE)) |=> !req_tready)
      else $error("input taken while compute running");

endmodule
